@@ sv/slts_pkg.sv @@
package slts_pkg;

	localparam int GridRows = 32;
	localparam int GridCols = 32;
	localparam int Nodes = GridRows * GridCols;
	localparam int RowW = $clog2(GridRows);
	localparam int ColW = $clog2(GridCols);
	localparam int NodeW = RowW + ColW;
	localparam int WordW = 32;
	localparam int MemW = 3 * WordW;
	localparam int SumW = 48;
	localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

	typedef enum logic [1:0] {
		OP_TRAIN = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		REG_LEARN_RATE = 3'd0,
		REG_RADIUS_SQ  = 3'd1,
		REG_WRAP_MODE  = 3'd2,
		REG_STEP_LIMIT = 3'd3,
		REG_STOP_THR   = 3'd4
	} reg_index_t;

	// Item carried on the input channel.
	typedef struct packed {
		logic [1:0]        opcode;
		logic [4:0]        node_row;
		logic [4:0]        node_col;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
	} in_item_t;

	// Item carried on the output channel.
	typedef struct packed {
		logic [4:0]         winner_row;
		logic [4:0]         winner_col;
		logic [SumW-1:0]    change_sum;
		logic               done_res;
		logic signed [31:0] weight_x;
		logic signed [31:0] weight_y;
		logic signed [31:0] weight_z;
	} out_item_t;

	// Saturating add on the 48-bit change total.
	function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
			input logic [SumW-1:0] b);
		logic [SumW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SumW] ? SumMax : s[SumW-1:0];
	endfunction

endpackage

@@ sv/slts_if.sv @@
interface slts_in_if;
	import slts_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface slts_out_if;
	import slts_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/slts_ram.sv @@
module slts_ram #(
	parameter int Width = 96,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/slts_move.sv @@
// Moves one weight component toward its sample component: the multiply is
// registered, and the rounding and sign are applied combinationally after it.
module slts_move import slts_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] sample,
	input  logic signed [31:0] weight,
	input  logic [15:0]        rate,
	output logic signed [31:0] new_weight,
	output logic [31:0]        step_mag
);

	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic [48:0]        prod_s1;
	logic               neg_s1;
	logic signed [31:0] weight_s1;
	logic [32:0]        p;

	assign diff = 33'(sample) - 33'(weight);
	assign mag = diff[32] ? 33'(-diff) : diff;

	always_ff @(posedge clk) begin
		prod_s1 <= 49'(mag) * 49'(rate);
		neg_s1 <= diff[32];
		weight_s1 <= weight;
	end

	// The step never passes the sample, so it fits in 32 bits once applied.
	assign p = 33'((prod_s1 + 49'd32768) >> 16);
	assign new_weight = neg_s1 ? weight_s1 - p[31:0] : weight_s1 + p[31:0];
	assign step_mag = p[31:0];

endmodule

@@ sv/som_lattice_train_step_core.sv @@
// A 32x32 self-organising map held in one 96-bit-wide memory, one node per
// entry. A train item makes one search pass over all 1024 nodes (one memory
// read a cycle), then a pass that updates the winner and then, in turn, every
// node within the neighbourhood radius, the winner included once more (one
// read-modify-write a node per cycle once the winner's first write has
// landed); the single read and single write port of the weight memory set
// that pace.
// The weight memory is not cleared at reset; read only nodes that were written.
module som_lattice_train_step_core import slts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	slts_in_if.sink     in_ch,
	slts_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SEARCH = 6'b000010,
		ST_UPDATE = 6'b000100,
		ST_READ   = 6'b001000,
		ST_FINISH = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	state_t state_q;

	logic [15:0] learn_rate_q;
	logic [11:0] radius_sq_q;
	logic        wrap_mode_q;
	logic [19:0] step_limit_q;
	logic [15:0] stop_thr_q;
	logic [19:0] step_count_q;
	logic        done_q;

	in_item_t    item_q;
	out_item_t   res_q;
	out_item_t   res_d;
	logic        res_valid_q;

	// Configuration port.
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q <= 16'd655;
			radius_sq_q <= 12'd1024;
			wrap_mode_q <= 1'b0;
			step_limit_q <= 20'd200000;
			stop_thr_q <= 16'd0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_LEARN_RATE: learn_rate_q <= pwdata[15:0];
				REG_RADIUS_SQ:  radius_sq_q <= pwdata[11:0];
				REG_WRAP_MODE:  wrap_mode_q <= pwdata[0];
				REG_STEP_LIMIT: step_limit_q <= pwdata[19:0];
				REG_STOP_THR:   stop_thr_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_LEARN_RATE: prdata = {16'd0, learn_rate_q};
			REG_RADIUS_SQ:  prdata = {20'd0, radius_sq_q};
			REG_WRAP_MODE:  prdata = {31'd0, wrap_mode_q};
			REG_STEP_LIMIT: prdata = {12'd0, step_limit_q};
			REG_STOP_THR:   prdata = {16'd0, stop_thr_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Weight memory, written by the update pass and by write items.
	logic             mem_we;
	logic [NodeW-1:0] mem_waddr, mem_raddr;
	logic [MemW-1:0]  mem_wdata, mem_rdata;
	logic             wr_item;
	logic             ram_we_all;
	logic [NodeW-1:0] ram_waddr_all;
	logic [MemW-1:0]  ram_wdata_all;

	slts_ram #(.Width(MemW), .Depth(Nodes)) u_ram (
		.clk(clk), .we(ram_we_all), .waddr(ram_waddr_all), .wdata(ram_wdata_all),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	// Read address counter, with the registered pipeline trailing behind it.
	logic [NodeW:0]   rd_cnt_q;      // issued reads, counts to Nodes
	logic             rd_v_s1;       // data for rd_node_s1 is on mem_rdata
	logic [NodeW-1:0] rd_node_s1;
	logic             upd_first_q;   // next issued read is the winner pass

	// Search: distance pipeline, per component square in one stage.
	logic [63:0]      sq_s2 [3];
	logic             sq_v_s2;
	logic [NodeW-1:0] sq_node_s2;
	logic [65:0]      best_q;
	logic [NodeW-1:0] best_node_q;
	logic             best_any_q;

	logic signed [31:0] smp [3];
	assign smp[0] = item_q.value_x;
	assign smp[1] = item_q.value_y;
	assign smp[2] = item_q.value_z;

	logic signed [31:0] rw [3];
	assign rw[0] = mem_rdata[95:64];
	assign rw[1] = mem_rdata[63:32];
	assign rw[2] = mem_rdata[31:0];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			logic signed [32:0] d;
			logic [32:0] m;
			d = 33'(smp[k]) - 33'(rw[k]);
			m = d[32] ? 33'(-d) : d;
			sq_s2[k] <= 64'(m) * 64'(m);
		end
		sq_node_s2 <= rd_node_s1;
	end

	logic [65:0] node_dist;
	assign node_dist = 66'(sq_s2[0]) + 66'(sq_s2[1]) + 66'(sq_s2[2]);

	// Update: the mover pipeline and the neighbourhood test.
	logic signed [31:0] nw [3];
	logic [31:0]        pm [3];
	logic               mv_v_s2, mv_in_s2, mv_v_s1_in;
	logic [NodeW-1:0]   mv_node_s2;
	logic               in_reach;

	for (genvar k = 0; k < 3; k++) begin : g_move
		slts_move u_move (
			.clk(clk), .sample(smp[k]), .weight(rw[k]), .rate(learn_rate_q),
			.new_weight(nw[k]), .step_mag(pm[k])
		);
	end

	logic [RowW-1:0] wr_row, nr;
	logic [ColW-1:0] wr_col, nc;
	logic [RowW:0]   dr, dc_w;
	logic [RowW:0]   dr_alt;
	logic [2*RowW+2:0] gd;
	assign wr_row = best_node_q[NodeW-1:ColW];
	assign wr_col = best_node_q[ColW-1:0];
	assign nr = rd_node_s1[NodeW-1:ColW];
	assign nc = rd_node_s1[ColW-1:0];
	always_comb begin
		dr = (nr > wr_row) ? (RowW+1)'(nr - wr_row) : (RowW+1)'(wr_row - nr);
		dr_alt = (RowW+1)'(GridRows) - dr;
		if (!wrap_mode_q && dr_alt < dr) begin
			dr = dr_alt;
		end
		dc_w = (nc > wr_col) ? (RowW+1)'(nc - wr_col) : (RowW+1)'(wr_col - nc);
		gd = (2*RowW+3)'(dr) * (2*RowW+3)'(dr) + (2*RowW+3)'(dc_w) * (2*RowW+3)'(dc_w);
		in_reach = gd <= (2*RowW+3)'(radius_sq_q);
	end

	// The winner pass is always applied; later passes only within reach.
	logic mv_first_s1;
	assign mv_v_s1_in = mv_first_s1 || in_reach;

	always_ff @(posedge clk) begin
		rd_node_s1 <= rd_addr;
		mv_node_s2 <= rd_node_s1;
		mv_in_s2 <= mv_v_s1_in;
	end

	logic [SumW-1:0] sum_q;
	logic [33:0]     pm_tot;
	assign pm_tot = 34'(pm[0]) + 34'(pm[1]) + 34'(pm[2]);

	// Control and pipeline valids.
	logic in_fire, out_fire, rd_issue, rd_last;
	logic [NodeW-1:0] rd_addr;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_ch.valid && out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !res_valid_q;
	assign out_ch.valid = res_valid_q;
	assign out_ch.data = res_q;

	always_comb begin
		rd_issue = 1'b0;
		rd_addr = rd_cnt_q[NodeW-1:0];
		if (state_q == ST_SEARCH) begin
			rd_issue = !rd_cnt_q[NodeW];
		end else if (state_q == ST_UPDATE) begin
			// Each node's write lands before any later read of it; the winner
			// is read again only after its first pass was written.
			rd_issue = !rd_cnt_q[NodeW] && !(upd_first_q == 1'b0 && rd_cnt_q == '0
				&& (rd_v_s1 || mv_v_s2));
			if (upd_first_q) begin
				rd_addr = best_node_q;
			end
		end else if (state_q == ST_READ) begin
			rd_addr = {item_q.node_row, item_q.node_col};
		end
		rd_last = rd_cnt_q[NodeW];
	end

	assign mem_raddr = rd_addr;
	assign mem_we = (state_q == ST_UPDATE) && mv_v_s2 && mv_in_s2;
	assign mem_waddr = mv_node_s2;
	assign mem_wdata = {nw[0], nw[1], nw[2]};

	logic [19:0] step_next;
	assign step_next = step_count_q + 20'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_cnt_q <= '0;
			rd_v_s1 <= 1'b0;
			sq_v_s2 <= 1'b0;
			mv_v_s2 <= 1'b0;
			mv_first_s1 <= 1'b0;
			upd_first_q <= 1'b0;
			best_any_q <= 1'b0;
			step_count_q <= '0;
			done_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_issue;
			sq_v_s2 <= rd_v_s1 && (state_q == ST_SEARCH);
			mv_v_s2 <= rd_v_s1 && (state_q == ST_UPDATE);
			if (rd_issue) begin
				mv_first_s1 <= upd_first_q && (state_q == ST_UPDATE);
			end
			if (out_fire) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (in_ch.data.opcode)
							OP_TRAIN: begin
								state_q <= ST_SEARCH;
								rd_cnt_q <= '0;
								best_any_q <= 1'b0;
							end
							OP_READ: state_q <= ST_READ;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SEARCH: begin
					if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + (NodeW+1)'(1);
					end
					if (sq_v_s2) begin
						best_any_q <= 1'b1;
					end
					if (rd_last && !rd_v_s1 && !sq_v_s2) begin
						state_q <= ST_UPDATE;
						rd_cnt_q <= '0;
						upd_first_q <= 1'b1;
					end
				end
				ST_UPDATE: begin
					if (rd_issue) begin
						if (upd_first_q) begin
							upd_first_q <= 1'b0;
						end else begin
							rd_cnt_q <= rd_cnt_q + (NodeW+1)'(1);
						end
					end
					if (rd_last && !rd_v_s1 && !mv_v_s2) begin
						state_q <= ST_FINISH;
					end
				end
				ST_READ: state_q <= ST_OUT;
				ST_FINISH: begin
					step_count_q <= step_next;
					if (step_next == step_limit_q || sum_q <= SumW'(stop_thr_q)) begin
						done_q <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					res_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result item, assembled from the item's opcode.
	always_comb begin
		res_d = '0;
		res_d.done_res = done_q;
		unique case (item_q.opcode)
			OP_TRAIN: begin
				res_d.winner_row = 5'(wr_row);
				res_d.winner_col = 5'(wr_col);
				res_d.change_sum = sum_q;
			end
			OP_READ: begin
				res_d.weight_x = rw[0];
				res_d.weight_y = rw[1];
				res_d.weight_z = rw[2];
			end
			OP_WRITE, OP_NONE: ;
			default: ;
		endcase
	end

	// Payload: the item, the running best and the change total.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_ch.data;
			sum_q <= '0;
		end
		if (sq_v_s2 && (!best_any_q || node_dist < best_q)) begin
			best_q <= node_dist;
			best_node_q <= sq_node_s2;
		end
		if (mem_we) begin
			sum_q <= sat_add(sum_q, SumW'(pm_tot));
		end
		if (state_q == ST_OUT) begin
			res_q <= res_d;
		end
	end

	// A write item goes to memory from the item register in the output state.
	assign wr_item = (state_q == ST_OUT) && (item_q.opcode == OP_WRITE);
	assign ram_we_all = mem_we || wr_item;
	assign ram_waddr_all = wr_item ? {item_q.node_row, item_q.node_col} : mem_waddr;
	assign ram_wdata_all = wr_item ? {item_q.value_x, item_q.value_y, item_q.value_z}
		: mem_wdata;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready)
		else $error("item accepted while busy");
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("done flag dropped");
	a_write_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_UPDATE))
		else $error("weight write outside update pass");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import slts_pkg::*;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	slts_in_if in_if ();
	slts_out_if out_if ();

	som_lattice_train_step_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_if),
		.out_ch  (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Own copy of the lattice, the step counter and the register file.
	logic signed [31:0] lattice [Nodes][3];
	logic [19:0] step_cnt;
	logic done_seen;
	logic [15:0] rate_q16;
	logic [11:0] radius_sq;
	logic wrap_plane;
	logic [19:0] step_lim;
	logic [15:0] stop_thr;

	out_item_t expected_results [$];
	int errors = 0;
	int send_idle = 27;
	int recv_idle = 76;
	logic hold_rx = 1'b0;

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit, well beyond the slowest correct run.
	initial begin
		#40000000;
		$display("tb failed");
		$finish;
	end

	function automatic logic [SumW-1:0] change_add(input logic [SumW-1:0] a,
			input logic [SumW-1:0] b);
		logic [SumW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
	endfunction

	// Moves one node towards the sample and returns the step magnitudes added up.
	function automatic logic [SumW-1:0] pull_node(input int n,
			input logic signed [31:0] smp [3]);
		longint d;
		logic [63:0] m;
		logic [63:0] p;
		logic [SumW-1:0] tot;
		tot = '0;
		for (int k = 0; k < 3; k++) begin
			d = longint'(smp[k]) - longint'(lattice[n][k]);
			m = d < 0 ? 64'(-d) : 64'(d);
			p = (m * 64'(rate_q16) + 64'd32768) >> 16;
			lattice[n][k] = d < 0 ? 32'(longint'(lattice[n][k]) - longint'(p))
				: 32'(longint'(lattice[n][k]) + longint'(p));
			tot = change_add(tot, p[SumW-1:0]);
		end
		return tot;
	endfunction

	// Works out the result of one item and updates the lattice copy.
	function automatic out_item_t predict_som(input in_item_t it);
		out_item_t r;
		logic signed [31:0] smp [3];
		int best;
		int wr;
		int wc;
		int dr;
		int dc;
		longint d;
		logic [63:0] m;
		logic [65:0] sq_dist;
		logic [65:0] bdist;
		logic [SumW-1:0] sum;
		r = '0;
		smp[0] = it.value_x;
		smp[1] = it.value_y;
		smp[2] = it.value_z;
		case (opcode_t'(it.opcode))
			OP_TRAIN: begin
				best = 0;
				bdist = '0;
				for (int n = 0; n < Nodes; n++) begin
					sq_dist = '0;
					for (int k = 0; k < 3; k++) begin
						d = longint'(smp[k]) - longint'(lattice[n][k]);
						m = d < 0 ? 64'(-d) : 64'(d);
						sq_dist = sq_dist + {2'b00, m * m};
					end
					// Ties keep the earlier node.
					if (n == 0 || sq_dist < bdist) begin
						best = n;
						bdist = sq_dist;
					end
				end
				wr = best / GridCols;
				wc = best % GridCols;
				// The winner moves once on its own, then again inside the neighbourhood.
				sum = pull_node(best, smp);
				for (int rr = 0; rr < GridRows; rr++) begin
					dr = rr > wr ? rr - wr : wr - rr;
					if (!wrap_plane && GridRows - dr < dr)
						dr = GridRows - dr;
					for (int cc = 0; cc < GridCols; cc++) begin
						dc = cc > wc ? cc - wc : wc - cc;
						if (dr * dr + dc * dc <= int'(radius_sq))
							sum = change_add(sum, pull_node(rr * GridCols + cc, smp));
					end
				end
				step_cnt = step_cnt + 20'd1;
				if (step_cnt == step_lim || sum <= SumW'(stop_thr))
					done_seen = 1'b1;
				r.winner_row = 5'(wr);
				r.winner_col = 5'(wc);
				r.change_sum = sum;
			end
			OP_WRITE: begin
				for (int k = 0; k < 3; k++)
					lattice[it.node_row * GridCols + it.node_col][k] = smp[k];
			end
			OP_READ: begin
				r.weight_x = lattice[it.node_row * GridCols + it.node_col][0];
				r.weight_y = lattice[it.node_row * GridCols + it.node_col][1];
				r.weight_z = lattice[it.node_row * GridCols + it.node_col][2];
			end
			default: ;
		endcase
		r.done_res = done_seen;
		return r;
	endfunction

	// Receiver: random stalls, long hold-offs, and the check of every result.
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (out_if.valid && out_if.ready) begin
			got = out_if.data;
			if (expected_results.size() == 0) begin
				$error("result with none expected");
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.winner_row !== want.winner_row) begin
					$error("winner_row exp %0d got %0d", want.winner_row, got.winner_row);
					errors++;
				end
				if (got.winner_col !== want.winner_col) begin
					$error("winner_col exp %0d got %0d", want.winner_col, got.winner_col);
					errors++;
				end
				if (got.change_sum !== want.change_sum) begin
					$error("change_sum exp %0h got %0h", want.change_sum, got.change_sum);
					errors++;
				end
				if (got.done_res !== want.done_res) begin
					$error("done_res exp %0b got %0b", want.done_res, got.done_res);
					errors++;
				end
				if (got.weight_x !== want.weight_x) begin
					$error("weight_x exp %0h got %0h", want.weight_x, got.weight_x);
					errors++;
				end
				if (got.weight_y !== want.weight_y) begin
					$error("weight_y exp %0h got %0h", want.weight_y, got.weight_y);
					errors++;
				end
				if (got.weight_z !== want.weight_z) begin
					$error("weight_z exp %0h got %0h", want.weight_z, got.weight_z);
					errors++;
				end
			end
		end
		out_if.ready <= !hold_rx && ($urandom_range(99) >= recv_idle);
	end

	// Offers one item, idling at random first, and records its result once taken.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data <= it;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		expected_results.insert(expected_results.size(), predict_som(it));
	endtask

	// Stops sending and waits for every outstanding result.
	task automatic wait_drained();
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input reg_index_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_LEARN_RATE: rate_q16 = val[15:0];
			REG_RADIUS_SQ: radius_sq = val[11:0];
			REG_WRAP_MODE: wrap_plane = val[0];
			REG_STEP_LIMIT: step_lim = val[19:0];
			REG_STOP_THR: stop_thr = val[15:0];
			default: ;
		endcase
	endtask

	function automatic in_item_t make_item(input opcode_t op, input int row, input int col,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		in_item_t it;
		it.opcode = op;
		it.node_row = 5'(row);
		it.node_col = 5'(col);
		it.value_x = x;
		it.value_y = y;
		it.value_z = z;
		return it;
	endfunction

	// Either a full-range word or a small signed one.
	function automatic logic [31:0] rand_word();
		if ($urandom_range(1))
			return $urandom;
		return 32'($signed($urandom_range(2097152)) - 1048576);
	endfunction

	// Every node gets written before anything reads or trains against it.
	task automatic test_fill_lattice();
		for (int n = 0; n < Nodes; n++)
			send_item(make_item(OP_WRITE, n / GridCols, n % GridCols,
				32'($signed($urandom_range(16777216)) - 8388608),
				32'($signed($urandom_range(16777216)) - 8388608),
				32'($signed($urandom_range(16777216)) - 8388608)));
		wait_drained();
	endtask

	task automatic test_directed();
		send_item(make_item(OP_WRITE, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_item(make_item(OP_WRITE, 31, 31, 32'h80000000, 32'h80000000, 32'h80000000));
		send_item(make_item(OP_READ, 0, 0, 32'hffffffff, 32'h0, 32'hffffffff));
		send_item(make_item(OP_READ, 31, 31, 32'h0, 32'hffffffff, 32'h0));
		send_item(make_item(OP_NONE, 31, 31, 32'hffffffff, 32'hffffffff, 32'hffffffff));
		// Two nodes equally close to the sample: the earlier one must win.
		send_item(make_item(OP_WRITE, 3, 4, 32'h40000000, 32'h40000000, 32'h40000000));
		send_item(make_item(OP_WRITE, 7, 9, 32'h40000000, 32'h40000000, 32'h40000000));
		send_item(make_item(OP_TRAIN, 0, 0, 32'h40000000, 32'h40000000, 32'h40000000));
		send_item(make_item(OP_TRAIN, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		send_item(make_item(OP_TRAIN, 31, 31, 32'h80000000, 32'h80000000, 32'h80000000));
		send_item(make_item(OP_READ, 3, 4, 0, 0, 0));
		send_item(make_item(OP_READ, 7, 9, 0, 0, 0));
		wait_drained();
		// Full rate, tiny radius, then the whole lattice on a plane.
		reg_write(REG_LEARN_RATE, 32'hffff);
		reg_write(REG_RADIUS_SQ, 32'd0);
		send_item(make_item(OP_TRAIN, 0, 0, 32'h00010000, 32'hffff0000, 32'h0));
		send_item(make_item(OP_READ, 0, 0, 0, 0, 0));
		wait_drained();
		reg_write(REG_RADIUS_SQ, 32'd2048);
		reg_write(REG_WRAP_MODE, 32'd1);
		reg_write(REG_LEARN_RATE, 32'd32768);
		send_item(make_item(OP_TRAIN, 0, 0, 32'h00120000, 32'h00340000, 32'hfff00000));
		send_item(make_item(OP_READ, 16, 16, 0, 0, 0));
		wait_drained();
	endtask

	task automatic test_random(input int count, input int s_idle, input int r_idle);
		int pick;
		opcode_t op;
		send_idle = s_idle;
		recv_idle = r_idle;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			op = pick < 55 ? OP_WRITE : pick < 83 ? OP_READ : pick < 97 ? OP_TRAIN : OP_NONE;
			send_item(make_item(op, $urandom_range(31), $urandom_range(31),
				rand_word(), rand_word(), rand_word()));
		end
		wait_drained();
	endtask

	// The receiver holds off while the sender keeps offering items.
	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		fork
			begin
				hold_rx <= 1'b1;
				repeat (600) @(posedge clk);
				hold_rx <= 1'b0;
			end
		join_none
		for (int i = 0; i < 24; i++)
			send_item(make_item(i % 3 == 0 ? OP_WRITE : OP_READ, $urandom_range(31),
				$urandom_range(31), rand_word(), rand_word(), rand_word()));
		send_item(make_item(OP_TRAIN, 0, 0, rand_word(), rand_word(), rand_word()));
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_if.valid = 1'b0;
		in_if.data = '0;
		for (int n = 0; n < Nodes; n++)
			for (int k = 0; k < 3; k++)
				lattice[n][k] = '0;
		step_cnt = '0;
		done_seen = 1'b0;
		rate_q16 = 16'd655;
		radius_sq = 12'd1024;
		wrap_plane = 1'b0;
		step_lim = 20'd200000;
		stop_thr = 16'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_lattice();
		test_directed();
		reg_write(REG_LEARN_RATE, 32'($urandom_range(65535)));
		reg_write(REG_RADIUS_SQ, 32'($urandom_range(40)));
		reg_write(REG_WRAP_MODE, 32'd0);
		test_random(85, 27, 76);
		reg_write(REG_WRAP_MODE, 32'd1);
		reg_write(REG_RADIUS_SQ, 32'($urandom_range(2048)));
		reg_write(REG_STEP_LIMIT, 32'd1);
		test_random(85, 76, 27);
		test_backpressure();
		// Extremes that raise the done flag for good.
		reg_write(REG_LEARN_RATE, 32'd0);
		reg_write(REG_STEP_LIMIT, 32'hfffff);
		reg_write(REG_STOP_THR, 32'hffff);
		test_random(40, 0, 0);
		reg_write(REG_LEARN_RATE, 32'd655);
		reg_write(REG_RADIUS_SQ, 32'd2048);
		reg_write(REG_WRAP_MODE, 32'd0);
		test_random(40, 0, 0);

		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
